FILE: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define ASSERT_CLKD_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sct_pkg.sv
package sct_pkg;

    localparam int SLOTS            = 256;
    localparam int WORDS_PER_SECTOR = 128;

    localparam int LBA_W   = 32;
    localparam int DATA_W  = 32;
    localparam int WORD_W  = 7;
    localparam int USED_W  = 9;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W  = $clog2(SLOTS + 1);
    localparam int DATA_AW = (SLOTS * WORDS_PER_SECTOR > 1) ?
                             $clog2(SLOTS * WORDS_PER_SECTOR) : 1;

    // Operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DUP      = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [LBA_W-1:0]  lba;
        logic [WORD_W-1:0] word_index;
        logic [DATA_W-1:0] data_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [2:0]        status;
        logic              forward_to_disk;
        logic [USED_W-1:0] used_count;
    } out_item_t;

endpackage

FILE: hdl/sct_ram.sv
module sct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/sector_cache_table_top.sv
// The block holds one item at a time and takes no new item until the previous result has
// moved into the output register. A full-table load or reserved op skips the search and
// the data access; with the disk present the tag search, one compare per cycle through the
// single tag RAM read port, is longest, SLOTS compares, when the table is full.
// Reset (rst_n, asynchronous, active low) empties the table, clears disk_present,
// and drops out_valid; tag and data memories are not cleared.
module sector_cache_table_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sct_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sct_pkg::out_item_t   out_item
);

    // The sequencer takes one item at a time. In IDLE an item is latched and the
    // path is chosen: reserved ops and loads into a full table finish at once,
    // identity mapping (no disk) resolves the slot from the address directly, and
    // with the disk present the SEARCH state walks the committed tags. ACCESS then
    // does the one data RAM access the op needs, RD_WAIT collects read data, and
    // DONE moves the result into the output register once that register is free.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ACCESS,
        S_RD_WAIT,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    sct_pkg::in_item_t              item_reg, item_next;
    logic                           disk_reg, disk_next;
    logic [sct_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [sct_pkg::FILL_W-1:0]     idx_reg, idx_next;
    logic [sct_pkg::SLOT_W-1:0]     cmp_slot_reg, cmp_slot_next;
    logic                           pending_reg, pending_next;
    logic                           hit_reg, hit_next;
    logic [sct_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    sct_pkg::out_item_t             res_reg, res_next;
    sct_pkg::out_item_t             out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    // Tag memory: one tag per slot, read one entry per cycle during the search.
    logic                           tag_we;
    logic                           tag_re;
    logic [sct_pkg::LBA_W-1:0]      tag_rdata;

    // Data memory: SLOTS sectors of WORDS_PER_SECTOR words, sector-major.
    logic                           dat_we;
    logic                           dat_re;
    logic [sct_pkg::DATA_AW-1:0]    dat_addr;
    logic [sct_pkg::DATA_W-1:0]     dat_rdata;

    logic [sct_pkg::SLOT_W-1:0]     acc_slot;
    logic                           word_ok;
    logic                           word_last;

    // Loads always target the next free slot; reads and writes target the hit slot.
    assign acc_slot  = (item_reg.op == sct_pkg::OP_LOAD) ?
                       fill_reg[sct_pkg::SLOT_W-1:0] : slot_reg;
    assign dat_addr  = sct_pkg::DATA_AW'(acc_slot) *
                       sct_pkg::DATA_AW'(sct_pkg::WORDS_PER_SECTOR) +
                       sct_pkg::DATA_AW'(item_reg.word_index);
    assign word_ok   = 32'(item_reg.word_index) < 32'(sct_pkg::WORDS_PER_SECTOR);
    assign word_last = 32'(item_reg.word_index) == 32'(sct_pkg::WORDS_PER_SECTOR - 1);

    sct_ram #(
        .WIDTH (sct_pkg::LBA_W),
        .DEPTH (sct_pkg::SLOTS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (fill_reg[sct_pkg::SLOT_W-1:0]),
        .wr_data (item_reg.lba),
        .rd_en   (tag_re),
        .rd_addr (idx_reg[sct_pkg::SLOT_W-1:0]),
        .rd_data (tag_rdata)
    );

    sct_ram #(
        .WIDTH (sct_pkg::DATA_W),
        .DEPTH (sct_pkg::SLOTS * sct_pkg::WORDS_PER_SECTOR)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (dat_we),
        .wr_addr (dat_addr),
        .wr_data (item_reg.data_in),
        .rd_en   (dat_re),
        .rd_addr (dat_addr),
        .rd_data (dat_rdata)
    );

    // The block takes an input transfer only in IDLE; the output register lets
    // that happen while the previous result still waits downstream.
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        disk_next      = disk_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        cmp_slot_next  = cmp_slot_reg;
        pending_next   = pending_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        tag_we         = 1'b0;
        tag_re         = 1'b0;
        dat_we         = 1'b0;
        dat_re         = 1'b0;

        // The user writes configuration only while idle; the block does not enforce it.
        if (cfg_wr_en)
        begin
            disk_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next    = in_item;
                    res_next     = '0;
                    idx_next     = '0;
                    pending_next = 1'b0;
                    if (in_item.op == sct_pkg::OP_RSVD)
                    begin
                        state_next = S_DONE;
                    end
                    else if (in_item.op == sct_pkg::OP_LOAD &&
                             fill_reg >= sct_pkg::FILL_W'(sct_pkg::SLOTS))
                    begin
                        res_next.status = sct_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else if (disk_reg)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        // Identity mapping: an address below SLOTS is its own slot.
                        hit_next   = in_item.lba < sct_pkg::LBA_W'(sct_pkg::SLOTS);
                        slot_next  = in_item.lba[sct_pkg::SLOT_W-1:0];
                        state_next = S_ACCESS;
                    end
                end
            end

            S_SEARCH:
            begin
                // Compare the tag read last cycle while the next one is fetched.
                if (pending_reg && tag_rdata == item_reg.lba)
                begin
                    hit_next   = 1'b1;
                    slot_next  = cmp_slot_reg;
                    state_next = S_ACCESS;
                end
                else if (idx_reg < fill_reg)
                begin
                    tag_re        = 1'b1;
                    pending_next  = 1'b1;
                    cmp_slot_next = idx_reg[sct_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_ACCESS;
                end
            end

            S_ACCESS:
            begin
                state_next = S_DONE;
                case (item_reg.op)
                    sct_pkg::OP_READ:
                    begin
                        if (hit_reg)
                        begin
                            if (word_ok)
                            begin
                                dat_re     = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                        end
                        else
                        begin
                            res_next.status          = disk_reg ? sct_pkg::ST_MISS :
                                                                  sct_pkg::ST_NOTFOUND;
                            res_next.forward_to_disk = disk_reg;
                        end
                    end
                    sct_pkg::OP_LOAD:
                    begin
                        if (hit_reg)
                        begin
                            res_next.status = sct_pkg::ST_DUP;
                        end
                        else
                        begin
                            dat_we = word_ok;
                            // The tag commits with the last word of the sector.
                            if (word_last)
                            begin
                                tag_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                    end
                    sct_pkg::OP_WRITE:
                    begin
                        res_next.forward_to_disk = disk_reg;
                        if (hit_reg)
                        begin
                            dat_we = word_ok;
                        end
                        else
                        begin
                            res_next.status = disk_reg ? sct_pkg::ST_MISS :
                                                         sct_pkg::ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end

            S_RD_WAIT:
            begin
                res_next.read_data = dat_rdata;
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next            = res_reg;
                    out_next.used_count = sct_pkg::USED_W'(fill_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            disk_reg      <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            disk_reg      <= disk_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            cmp_slot_reg  <= cmp_slot_next;
            pending_reg   <= pending_next;
            hit_reg       <= hit_next;
            slot_reg      <= slot_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/sct_checker.sv
`include "assert_macros.svh"

module sct_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input sct_pkg::out_item_t  out_item
);

    // A stalled result stays valid and unchanged.
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")

    // One item at a time: after an input transfer the block stalls its input.
    `ASSERT_CLKD(a_one_item, clk, rst_n, in_valid && !in_stall |=> in_stall, "input taken while busy")

    // The committed slot count never passes the table size.
    `ASSERT_CLKD(a_used_max, clk, rst_n, out_valid |-> out_item.used_count <= sct_pkg::USED_W'(sct_pkg::SLOTS), "used_count beyond table size")

    // Read data is only non-zero on a hit.
    `ASSERT_CLKD(a_rdata_zero, clk, rst_n, out_valid && out_item.status != sct_pkg::ST_HIT |-> out_item.read_data == '0, "read_data set on a non-hit")

    // No result is offered while reset is asserted.
    `ASSERT_CLKD_RST(a_rst_quiet, clk, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind sector_cache_table_top sct_checker u_sct_checker (.*);

FILE: test/sector_cache_table_top_tb.sv
`timescale 1ns / 1ps

module sector_cache_table_top_tb;

    // The watchdog ends the run after this many cycles in which neither channel
    // completes a transfer. The slowest correct item needs one tag search of
    // SLOTS compares, and the long result hold-off is set by LONG_HOLD. Both are
    // far below this limit.
    localparam int QUIET_LIMIT  = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 480;

    // Kinds of rows in the directed table. A configuration row carries the new
    // disk_present value in bit 0 of its data_in field.
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        sct_pkg::in_item_t   access;
        sct_pkg::out_item_t  answer;
    } script_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    sct_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_stall;
    sct_pkg::out_item_t out_item;

    // A result typed into the table replaces the predicted one for the access
    // that is offered alongside it.
    bit                 offer_typed;
    sct_pkg::out_item_t offer_answer;

    // Predicted contents of the cache, updated at each accepted access.
    logic [sct_pkg::LBA_W-1:0]  tag_mem [sct_pkg::SLOTS];
    logic [sct_pkg::DATA_W-1:0] word_mem [sct_pkg::SLOTS * sct_pkg::WORDS_PER_SECTOR];
    bit                         word_written [sct_pkg::SLOTS * sct_pkg::WORDS_PER_SECTOR];
    int unsigned                committed;
    logic                       disk_on;

    sct_pkg::out_item_t pending_results [$];
    script_row_t        script [$];

    int            error_count;
    int            quiet_cycles;
    int            send_gap_pct;
    int            sink_stall_pct;
    int            hold_requests;

    // State of the sector load that the traffic generator is working through.
    logic [sct_pkg::LBA_W-1:0] load_lba;
    int unsigned               load_left;
    bit                        filling;

    sector_cache_table_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Looks a sector up the way the block does: identity mapping without the
    // disk, and a search over the committed tags with it.
    function automatic bit find_sector(input logic [sct_pkg::LBA_W-1:0] lba,
                                       output int unsigned slot);
        slot = 0;
        if (!disk_on)
        begin
            if (lba < sct_pkg::SLOTS)
            begin
                slot = lba;
                return 1'b1;
            end
            return 1'b0;
        end
        for (int unsigned i = 0; i < committed; i++)
        begin
            if (tag_mem[i] == lba)
            begin
                slot = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the result of one access and applies its effect on the cache.
    function automatic sct_pkg::out_item_t cache_predict(input sct_pkg::in_item_t acc);
        sct_pkg::out_item_t res;
        int unsigned        slot;
        int unsigned        addr;
        res = '0;
        res.status = sct_pkg::ST_HIT;
        case (acc.op)
            sct_pkg::OP_READ:
            begin
                if (find_sector(acc.lba, slot))
                begin
                    if (acc.word_index < sct_pkg::WORDS_PER_SECTOR)
                    begin
                        addr = slot * sct_pkg::WORDS_PER_SECTOR + acc.word_index;
                        res.read_data = word_mem[addr];
                    end
                end
                else if (disk_on)
                begin
                    res.status = sct_pkg::ST_MISS;
                    res.forward_to_disk = 1'b1;
                end
                else
                    res.status = sct_pkg::ST_NOTFOUND;
            end
            sct_pkg::OP_LOAD:
            begin
                if (committed >= sct_pkg::SLOTS)
                    res.status = sct_pkg::ST_FULL;
                else if (find_sector(acc.lba, slot))
                    res.status = sct_pkg::ST_DUP;
                else
                begin
                    if (acc.word_index < sct_pkg::WORDS_PER_SECTOR)
                    begin
                        addr = committed * sct_pkg::WORDS_PER_SECTOR + acc.word_index;
                        word_mem[addr] = acc.data_in;
                        word_written[addr] = 1'b1;
                    end
                    if (acc.word_index == sct_pkg::WORDS_PER_SECTOR - 1)
                    begin
                        tag_mem[committed] = acc.lba;
                        committed++;
                    end
                end
            end
            sct_pkg::OP_WRITE:
            begin
                res.forward_to_disk = disk_on;
                if (find_sector(acc.lba, slot))
                begin
                    if (acc.word_index < sct_pkg::WORDS_PER_SECTOR)
                    begin
                        addr = slot * sct_pkg::WORDS_PER_SECTOR + acc.word_index;
                        word_mem[addr] = acc.data_in;
                        word_written[addr] = 1'b1;
                    end
                end
                else
                    res.status = disk_on ? sct_pkg::ST_MISS : sct_pkg::ST_NOTFOUND;
            end
            default:
            begin
            end
        endcase
        res.used_count = sct_pkg::USED_W'(committed);
        return res;
    endfunction

    // Picks the next random access. Most traffic is sector loads of a few words
    // closed by the last word, and reads and writes of sectors already held.
    // The rest is misses, duplicate loads, reserved operations and loads that
    // are left unfinished.
    function automatic sct_pkg::in_item_t next_access();
        sct_pkg::in_item_t         acc;
        int unsigned               pick;
        int unsigned               kind;
        int unsigned               slot;
        int unsigned               tries;
        logic [sct_pkg::LBA_W-1:0] held_lba;
        acc.op = sct_pkg::OP_READ;
        acc.lba = $urandom();
        acc.word_index = sct_pkg::WORD_W'($urandom_range(sct_pkg::WORDS_PER_SECTOR - 1));
        acc.data_in = $urandom();
        pick = $urandom_range(99);
        kind = $urandom_range(99);
        if (disk_on && committed > 0)
            held_lba = tag_mem[$urandom_range(committed - 1)];
        else if (disk_on)
            held_lba = $urandom();
        else
            held_lba = $urandom_range(sct_pkg::SLOTS - 1);

        if (filling && committed < sct_pkg::SLOTS)
        begin
            // One-word sector loads that commit at once, to drive the table full.
            acc.op = sct_pkg::OP_LOAD;
            acc.word_index = sct_pkg::WORD_W'(sct_pkg::WORDS_PER_SECTOR - 1);
        end
        else
        begin
            if (load_left == 0 && pick < 20)
            begin
                load_lba = ($urandom_range(9) == 0) ? $urandom_range(sct_pkg::SLOTS - 1) :
                                                      $urandom();
                load_left = $urandom_range(1, 4);
            end
            if (load_left > 0 && pick < 70)
            begin
                acc.op = sct_pkg::OP_LOAD;
                acc.lba = load_lba;
                load_left--;
                if (load_left == 0)
                    acc.word_index = sct_pkg::WORD_W'(sct_pkg::WORDS_PER_SECTOR - 1);
            end
            else if (kind < 45)
            begin
                // Prefer a word that has been written; the check below covers
                // the case where none turns up.
                acc.lba = held_lba;
                for (tries = 0; tries < 4; tries++)
                begin
                    if (!find_sector(held_lba, slot) ||
                        word_written[slot * sct_pkg::WORDS_PER_SECTOR + acc.word_index])
                        break;
                    acc.word_index =
                        sct_pkg::WORD_W'($urandom_range(sct_pkg::WORDS_PER_SECTOR - 1));
                end
            end
            else if (kind < 75)
            begin
                acc.op = sct_pkg::OP_WRITE;
                acc.lba = held_lba;
            end
            else if (kind < 85)
                acc.op = kind[0] ? sct_pkg::OP_READ : sct_pkg::OP_WRITE;
            else if (kind < 93)
            begin
                acc.op = sct_pkg::OP_LOAD;
                acc.lba = held_lba;
            end
            else
                acc.op = sct_pkg::OP_RSVD;
        end

        // A read must never land on a cached word that was never written, so
        // such a read becomes a write of that word.
        if (acc.op == sct_pkg::OP_READ && find_sector(acc.lba, slot) &&
            acc.word_index < sct_pkg::WORDS_PER_SECTOR &&
            !word_written[slot * sct_pkg::WORDS_PER_SECTOR + acc.word_index])
            acc.op = sct_pkg::OP_WRITE;
        return acc;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [1:0] op,
                           input logic [sct_pkg::LBA_W-1:0] lba,
                           input logic [sct_pkg::WORD_W-1:0] word,
                           input logic [sct_pkg::DATA_W-1:0] data,
                           input logic [sct_pkg::DATA_W-1:0] rd,
                           input logic [2:0] st, input logic fwd,
                           input logic [sct_pkg::USED_W-1:0] used);
        script_row_t row;
        row.kind = kind;
        row.access.op = op;
        row.access.lba = lba;
        row.access.word_index = word;
        row.access.data_in = data;
        row.answer.read_data = rd;
        row.answer.status = st;
        row.answer.forward_to_disk = fwd;
        row.answer.used_count = used;
        script.push_back(row);
    endtask

    // Offers one access and returns at the falling edge after its transfer.
    // Called at a falling edge; valid stays high for a following access.
    task automatic send_item(input sct_pkg::in_item_t acc, input bit given,
                             input sct_pkg::out_item_t answer);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= acc;
        offer_typed <= given;
        offer_answer <= answer;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Writes disk_present once the block has delivered every pending result.
    task automatic set_disk(input logic on);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= on;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [sct_pkg::DATA_W-1:0] want,
                               input logic [sct_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // Scoreboard: predicts each accepted access and checks each accepted result
    // against the oldest prediction. The register write is mirrored here so the
    // predictor follows the same clock edge as the block.
    always @(posedge clk)
    begin : scoreboard
        sct_pkg::out_item_t want;
        if (!rst_n)
        begin
            committed = 0;
            disk_on = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                disk_on = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                want = cache_predict(in_item);
                if (offer_typed)
                    want = offer_answer;
                pending_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, out_item);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_data", want.read_data, out_item.read_data);
                    check_field("status", sct_pkg::DATA_W'(want.status),
                                sct_pkg::DATA_W'(out_item.status));
                    check_field("forward_to_disk", sct_pkg::DATA_W'(want.forward_to_disk),
                                sct_pkg::DATA_W'(out_item.forward_to_disk));
                    check_field("used_count", sct_pkg::DATA_W'(want.used_count),
                                sct_pkg::DATA_W'(out_item.used_count));
                end
            end
        end
    end

    // Watchdog: counts cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls at the current rate, and one long hold-off,
    // counted here, for each request from the stimulus, during which the sender
    // keeps offering accesses.
    initial
    begin : result_sink
        int hold_count;
        int holds_done;
        holds_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_count = 0;
                while (hold_count < LONG_HOLD)
                begin
                    out_stall <= 1'b1;
                    hold_count++;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b1;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        offer_typed = 1'b0;
        offer_answer = '0;
        hold_requests = 0;
        load_left = 0;
        load_lba = '0;
        filling = 1'b0;
        send_gap_pct = 9;
        sink_stall_pct = 83;

        // Directed table. The first rows run without the disk, right after
        // reset: identity-mapped slots, misses reported as not found, loads of
        // low addresses counted as duplicates, a load that commits a slot and
        // a reserved operation. Then the disk is switched on, and the rows
        // cover tag hits, misses sent to the disk, write-through, duplicate
        // loads, a load at the highest address and another reserved operation.
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'd256, 7'd0, 32'h0,
                32'h0, sct_pkg::ST_NOTFOUND, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'hFFFF_FFFF, 7'd127, 32'h0,
                32'h0, sct_pkg::ST_NOTFOUND, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_WRITE, 32'd0, 7'd0, 32'hFFFF_FFFF,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'd0, 7'd0, 32'h0,
                32'hFFFF_FFFF, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_WRITE, 32'd255, 7'd127, 32'h0,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'd255, 7'd127, 32'h0,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_WRITE, 32'd256, 7'd64, 32'h5A5A_5A5A,
                32'h0, sct_pkg::ST_NOTFOUND, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_LOAD, 32'd5, 7'd3, 32'h1234_5678,
                32'h0, sct_pkg::ST_DUP, 1'b0, 9'd0);
        add_row(ROW_PREDICTED, sct_pkg::OP_LOAD, 32'd256, 7'd0, 32'h0000_0001,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_LOAD, 32'd256, 7'd127, 32'h8000_0000,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd1);
        add_row(ROW_PREDICTED, sct_pkg::OP_READ, 32'd0, 7'd0, 32'h0,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_RSVD, 32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd1);
        add_row(ROW_CONFIG, sct_pkg::OP_READ, 32'd0, 7'd0, 32'd1,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'd256, 7'd127, 32'h0,
                32'h8000_0000, sct_pkg::ST_HIT, 1'b0, 9'd1);
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'd0, 7'd0, 32'h0,
                32'h0, sct_pkg::ST_MISS, 1'b1, 9'd1);
        add_row(ROW_TYPED, sct_pkg::OP_WRITE, 32'd256, 7'd5, 32'h1234_5678,
                32'h0, sct_pkg::ST_HIT, 1'b1, 9'd1);
        add_row(ROW_PREDICTED, sct_pkg::OP_READ, 32'd256, 7'd5, 32'h0,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_WRITE, 32'd7, 7'd0, 32'h0,
                32'h0, sct_pkg::ST_MISS, 1'b1, 9'd1);
        add_row(ROW_TYPED, sct_pkg::OP_LOAD, 32'd256, 7'd9, 32'h0,
                32'h0, sct_pkg::ST_DUP, 1'b0, 9'd1);
        add_row(ROW_PREDICTED, sct_pkg::OP_LOAD, 32'hFFFF_FFFF, 7'd0, 32'hCAFE_F00D,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_LOAD, 32'hFFFF_FFFF, 7'd127, 32'h7FFF_FFFF,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd2);
        add_row(ROW_PREDICTED, sct_pkg::OP_READ, 32'hFFFF_FFFF, 7'd0, 32'h0,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd0);
        add_row(ROW_TYPED, sct_pkg::OP_RSVD, 32'd0, 7'd0, 32'h0,
                32'h0, sct_pkg::ST_HIT, 1'b0, 9'd2);
        add_row(ROW_TYPED, sct_pkg::OP_READ, 32'hFFFF_FFFE, 7'd1, 32'h0,
                32'h0, sct_pkg::ST_MISS, 1'b1, 9'd2);

        // Reset goes low just after time zero so that the asynchronous reset
        // sees a clean falling edge, and is released at a falling clock edge.
        #1;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CONFIG:    set_disk(script[i].access.data_in[0]);
                ROW_TYPED:     send_item(script[i].access, 1'b1, script[i].answer);
                default:       send_item(script[i].access, 1'b0, '0);
            endcase
        end

        // Random part in three phases. The first runs without the disk while
        // the result side stalls often, the second with the disk while the
        // sender idles often, and the third with neither side idling. The
        // third starts with a long hold-off on the result side and then fills
        // the table, so that later loads see it full.
        for (int phase = 0; phase < 3; phase++)
        begin
            set_disk(phase != 0);
            send_gap_pct = (phase == 0) ? 9 : (phase == 1) ? 83 : 0;
            sink_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 9 : 0;
            filling = (phase == 2);
            if (phase == 2)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(next_access(), 1'b0, '0);
        end

        // Drain, then leave time for any stray result to show up.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (sct_pkg::SLOTS + 8) @(negedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
